[rtl/core/prsb_pkg.sv]
// Shared types, constants and build-time ring tables for the polar ring sector binner.
// No dependencies; every other file in the block imports this package.
package prsb_pkg;

  // Largest number of rings that have sector and offset tables.
  localparam int MAX_RINGS = 64;
  localparam int RING_AW   = $clog2(MAX_RINGS);

  localparam int RADIUS_W  = 14;
  localparam int ANGLE_W   = 16;
  localparam int COUNT_W   = 8;
  localparam int FACTOR_W  = 9;
  localparam int RPROD_W   = RADIUS_W + FACTOR_W;
  localparam int RING_W    = 9;
  localparam int QUOT_W    = 16;
  localparam int RECIP_W   = 13;
  localparam int QPROD_W   = QUOT_W + RECIP_W;
  localparam int SECT_W    = 10;
  localparam int APROD_W   = ANGLE_W + SECT_W;
  localparam int BIN_W     = 16;
  localparam int RSAT_W    = 7;

  // Rounding bias and scale of the ring quotient: ring = (p + 12800) / 25600,
  // done as a shift by 8 followed by a division by 100.
  localparam logic [RPROD_W:0] ROUND_BIAS  = (RPROD_W+1)'(12800);
  localparam int               PRE_SHIFT   = 8;
  // 5243 / 2^19 overestimates 1/100 by so little that for quotients
  // below 2^15 the truncated product is already the exact floor.
  localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5243);
  localparam int                 RECIP_SH  = 19;

  localparam logic [63:0] TWO_PI_Q32 = 64'd26986075409;
  localparam logic [COUNT_W-1:0] MAX_RINGS_CNT = COUNT_W'(MAX_RINGS);
  localparam logic [RSAT_W-1:0]  RING_SAT      = {RSAT_W{1'b1}};

  typedef logic [SECT_W-1:0] sect_tab_t [MAX_RINGS];
  typedef logic [BIN_W-1:0]  offs_tab_t [MAX_RINGS];

  // Sector count of ring l: floor(2*pi*l) + 1.
  function automatic logic [SECT_W-1:0] ring_sectors(input int l);
    logic [63:0] prod;
    prod = 64'(l) * TWO_PI_Q32;
    return SECT_W'(prod[63:32] + 32'd1);
  endfunction

  function automatic sect_tab_t build_sectors();
    sect_tab_t tab;
    for (int l = 0; l < MAX_RINGS; l++) begin
      tab[l] = ring_sectors(l);
    end
    return tab;
  endfunction

  // First bin of ring l: the sector counts of all lower rings summed.
  function automatic offs_tab_t build_offsets();
    offs_tab_t tab;
    logic [BIN_W-1:0] acc;
    acc = '0;
    for (int l = 0; l < MAX_RINGS; l++) begin
      tab[l] = acc;
      acc    = acc + BIN_W'(ring_sectors(l));
    end
    return tab;
  endfunction

  localparam sect_tab_t SECTOR_TAB = build_sectors();
  localparam offs_tab_t OFFSET_TAB = build_offsets();

  typedef struct packed {
    logic [RADIUS_W-1:0] radius;
    logic [ANGLE_W-1:0]  angle;
  } hit_t;

  typedef struct packed {
    logic [RING_W-1:0]  ring;
    logic [ANGLE_W-1:0] angle;
  } ring_beat_t;

  typedef struct packed {
    logic [BIN_W-1:0]  bin_index;
    logic [RSAT_W-1:0] ring_index;
    logic [SECT_W-1:0] sector_index;
    logic              out_of_range;
  } bin_result_t;

endpackage

[rtl/core/polar_ring_sector_binner.sv]
// Top level of the polar ring sector binner: streaming ports, the ring_count
// register and the two pipeline halves. Uses prsb_pkg, prsb_ring, prsb_sector.
//
// Usage:
// A hit enters on the s_axis channel as one beat holding radius (mm with 8
// fraction bits) and angle (65536 per full turn). One result beat leaves on
// m_axis for every hit, in order: bin, ring and sector in tdata, and the
// out-of-range flag in tuser.
// The ring count is written through the cfg channel, which is always ready;
// write it only while no hit is in flight. Counts above the table size still
// scale the ring, but only rings below the table size are in range, and a
// count of zero marks every hit out of range.
// Throughput is one beat per cycle while m_axis_tready is high; the figure is
// set by the four register stages (two multiplier stages for the ring, a
// lookup and multiplier stage for the sector, and the offset add), each of
// which takes a new beat every cycle unless it holds a beat it cannot pass on.
// When the receiver holds m_axis_tready low, the final stage holds its beat
// and each stage keeps accepting until it is full, so empty slots close up
// before s_axis_tready drops. Nothing is lost or repeated.
// Reset clears all valid bits and loads the ring count with 64.
module polar_ring_sector_binner
  import prsb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // radius[13:0], angle[29:14], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // bin_index[15:0], ring_index[22:16],
                                      // sector_index[32:23], zero pad
  output logic [0:0]  m_axis_tuser    // out_of_range
);

  localparam logic [COUNT_W-1:0] RING_COUNT_RST = COUNT_W'(64);

  logic [COUNT_W-1:0]  ring_count;
  logic [FACTOR_W-1:0] factor;
  logic [COUNT_W-1:0]  ring_limit;

  hit_t        hit;
  logic        mid_valid;
  logic        mid_ready;
  ring_beat_t  mid_beat;
  bin_result_t result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_count <= RING_COUNT_RST;
    end else if (cfg_valid) begin
      ring_count <= cfg_data;
    end
  end

  // The ring is round(r*(n-0.5)/50); the factor 2n-1 carries the half ring.
  assign factor     = (ring_count == '0) ? '0 : {ring_count, 1'b0} - FACTOR_W'(1);
  assign ring_limit = (ring_count > MAX_RINGS_CNT) ? MAX_RINGS_CNT : ring_count;

  assign hit.radius = s_axis_tdata[RADIUS_W-1:0];
  assign hit.angle  = s_axis_tdata[RADIUS_W +: ANGLE_W];

  prsb_ring u_ring (
    .clk       (clk),
    .rst       (rst),
    .factor    (factor),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_beat   (hit),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_beat  (mid_beat)
  );

  prsb_sector u_sector (
    .clk        (clk),
    .rst        (rst),
    .ring_limit (ring_limit),
    .in_valid   (mid_valid),
    .in_ready   (mid_ready),
    .in_beat    (mid_beat),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_beat   (result)
  );

  assign m_axis_tdata = {7'b0, result.sector_index, result.ring_index, result.bin_index};
  assign m_axis_tuser = result.out_of_range;

endmodule

[rtl/core/prsb_ring.sv]
// Ring computation for the polar ring sector binner: two pipeline stages that
// scale the radius by (2n-1) and divide by 25600 with rounding. Uses prsb_pkg.
module prsb_ring
  import prsb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [FACTOR_W-1:0] factor,
  input  logic                in_valid,
  output logic                in_ready,
  input  hit_t                in_beat,
  output logic                out_valid,
  input  logic                out_ready,
  output ring_beat_t          out_beat
);

  logic               a_valid;
  logic               a_ready;
  logic [RPROD_W-1:0] a_prod;
  logic [ANGLE_W-1:0] a_angle;

  logic               b_valid;
  logic               b_ready;
  logic [QPROD_W-1:0] b_quot;
  logic [ANGLE_W-1:0] b_angle;

  logic [RPROD_W:0]   biased;
  logic [QUOT_W-1:0]  scaled;

  assign b_ready  = !b_valid || out_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  // Stage A: radius times (2n-1).
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
    if (a_ready && in_valid) begin
      a_prod  <= RPROD_W'(in_beat.radius) * RPROD_W'(factor);
      a_angle <= in_beat.angle;
    end
  end

  assign biased = {1'b0, a_prod} + ROUND_BIAS;
  assign scaled = QUOT_W'(biased >> PRE_SHIFT);

  // Stage B: divide by 100 through the reciprocal.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
    if (b_ready && a_valid) begin
      b_quot  <= QPROD_W'(scaled) * QPROD_W'(RECIP_100);
      b_angle <= a_angle;
    end
  end

  assign out_valid      = b_valid;
  assign out_beat.ring  = b_quot[RECIP_SH +: RING_W];
  assign out_beat.angle = b_angle;

endmodule

[rtl/core/prsb_sector.sv]
// Sector and bin computation for the polar ring sector binner: table lookup,
// angle scaling and offset add over two pipeline stages. Uses prsb_pkg.
module prsb_sector
  import prsb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [COUNT_W-1:0] ring_limit,
  input  logic               in_valid,
  output logic               in_ready,
  input  ring_beat_t         in_beat,
  output logic               out_valid,
  input  logic               out_ready,
  output bin_result_t        out_beat
);

  logic               c_valid;
  logic               c_ready;
  logic               c_oor;
  logic [RSAT_W-1:0]  c_ring;
  logic [SECT_W-1:0]  c_sectors;
  logic [BIN_W-1:0]   c_offset;
  logic [APROD_W-1:0] c_prod;

  logic               d_valid;
  logic               d_ready;
  bin_result_t        d_beat;

  logic               oor;
  logic [RING_AW-1:0] tab_idx;
  logic [SECT_W-1:0]  sectors;
  logic [SECT_W-1:0]  raw_sector;
  logic [SECT_W-1:0]  sector;

  assign d_ready  = !d_valid || out_ready;
  assign c_ready  = !c_valid || d_ready;
  assign in_ready = c_ready;

  assign oor     = in_beat.ring >= RING_W'(ring_limit);
  assign tab_idx = oor ? '0 : in_beat.ring[RING_AW-1:0];
  assign sectors = SECTOR_TAB[tab_idx];

  // Stage C: look up the ring and scale the angle by its sector count.
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_ready) begin
      c_valid <= in_valid;
    end
    if (c_ready && in_valid) begin
      c_oor     <= oor;
      c_ring    <= (in_beat.ring > RING_W'(RING_SAT)) ? RING_SAT : in_beat.ring[RSAT_W-1:0];
      c_sectors <= sectors;
      c_offset  <= OFFSET_TAB[tab_idx];
      c_prod    <= APROD_W'(in_beat.angle) * APROD_W'(sectors);
    end
  end

  assign raw_sector = c_prod[ANGLE_W +: SECT_W];
  assign sector     = (raw_sector > c_sectors - 1'b1) ? c_sectors - 1'b1 : raw_sector;

  // Stage D: add the ring offset, zero the bin and sector of an out-of-range hit.
  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (d_ready) begin
      d_valid <= c_valid;
    end
    if (d_ready && c_valid) begin
      d_beat.bin_index    <= c_oor ? '0 : c_offset + BIN_W'(sector);
      d_beat.ring_index   <= c_ring;
      d_beat.sector_index <= c_oor ? '0 : sector;
      d_beat.out_of_range <= c_oor;
    end
  end

  assign out_valid = d_valid;
  assign out_beat  = d_beat;

endmodule

[rtl/core/prsb_checker.sv]
// Port-level checks for the polar ring sector binner, bound to the top level.
// Uses prsb_pkg.
module prsb_checker
  import prsb_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result beat changed");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |->
      m_axis_tdata[15:0] == 16'd0 && m_axis_tdata[32:23] == 10'd0)
    else $error("out-of-range beat carries a bin or sector");

  a_ring_in_table: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |->
      m_axis_tdata[22:16] < RSAT_W'(MAX_RINGS) &&
      m_axis_tdata[15:0] >= 16'(m_axis_tdata[32:23]))
    else $error("in-range beat has impossible ring or bin");

endmodule

bind polar_ring_sector_binner prsb_checker u_prsb_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[sim/polar_ring_sector_binner_test.sv]
// Self-checking testbench for polar_ring_sector_binner: a directed table of hits, then random
// hit streams under several ring counts, each beat checked against a typed row or map_hit.
// Depends on prsb_pkg and the polar_ring_sector_binner RTL.
module polar_ring_sector_binner_test;
  timeunit 1ns;
  timeprecision 1ps;

  import prsb_pkg::*;

  // Generous bound for about 725 hits with 6% idling on both sides.
  localparam int CYCLE_LIMIT = 200000;
  // Four pipeline stages; DRAIN_CYCLES is the idle wait after the last result before ending.
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_PHASES = 7;
  localparam int HITS_PER_PHASE = 100;
  localparam int IDLE_PERCENT = 6;
  localparam int DISC_EDGE = 12800;  // 50 mm with 8 fraction bits

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // radius[13:0], angle[29:14], zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // bin_index[15:0], ring_index[22:16],
                                    // sector_index[32:23], zero pad
  logic [0:0]  m_axis_tuser;        // out_of_range

  // Results expected from accepted hits, oldest first.
  bin_result_t pending_bins[$];
  // Our copy of the ring_count register.
  logic [7:0]  ring_count_now = 8'd64;
  // While set, neither side of the stream idles.
  bit          steady_stream = 1'b0;
  int          mismatch_count = 0;
  int          cycle_count = 0;

  // One directed hit. When 'typed' is set the expected result is written in the row;
  // otherwise the predictor supplies it.
  typedef struct {
    int count;
    int radius;
    int angle;
    int typed;
    int bin;
    int ring;
    int sect;
    int oor;
  } hit_case_t;

  localparam int DIRECTED_HITS = 22;
  hit_case_t directed_hits[DIRECTED_HITS] = '{
    // Reset ring count of 64: center, disc edge and field extremes.
    '{64,     0,     0, 1, 0,   0, 0, 0},
    '{64,     0, 65535, 1, 0,   0, 0, 0},
    '{64, 16383, 65535, 1, 0,  81, 0, 1},
    '{64, 16383,     0, 1, 0,  81, 0, 1},
    '{64, 12800,     0, 1, 0,  64, 0, 1},
    // Just inside the outermost ring, first and last sector.
    '{64, 12799,     0, 0, 0,   0, 0, 0},
    '{64, 12799, 65535, 0, 0,   0, 0, 0},
    // Either side of the ring 0 / ring 1 rounding boundary, then two mid-disc hits.
    '{64,   101, 32768, 0, 0,   0, 0, 0},
    '{64,   100, 32768, 0, 0,   0, 0, 0},
    '{64, 10922, 43690, 0, 0,   0, 0, 0},
    '{64,  5461, 21845, 0, 0,   0, 0, 0},
    // A count of zero puts every hit out of range at ring 0.
    '{ 0,     0,     0, 1, 0,   0, 0, 1},
    '{ 0, 16383, 65535, 1, 0,   0, 0, 1},
    // A single ring.
    '{ 1,     0, 12345, 1, 0,   0, 0, 0},
    '{ 1, 16383,     0, 1, 0,   1, 0, 1},
    '{ 1, 12799, 65535, 1, 0,   0, 0, 0},
    // Counts above the table size cap the in-range rings at the table size; ring saturates at 127.
    '{255, 16383, 65535, 1, 0, 127, 0, 1},
    '{255,  1000, 40000, 0, 0,   0, 0, 0},
    '{255,  3200, 65535, 1, 0,  64, 0, 1},
    '{128,  3150, 20000, 0, 0,   0, 0, 0},
    '{128, 12800,     1, 1, 0, 127, 0, 1},
    '{  2,  5120, 65535, 1, 7,   1, 6, 0}
  };

  polar_ring_sector_binner u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk = ~clk;

  // Number of angular sectors in ring l: floor(2*pi*l) + 1, from the Q32 constant.
  function automatic int sector_count(input int l);
    logic [63:0] scaled;
    scaled = 64'(l) * TWO_PI_Q32;
    return int'(scaled >> 32) + 1;
  endfunction

  // Bin mapping of one hit under a given ring count.
  function automatic bin_result_t map_hit(input logic [13:0] radius, input logic [15:0] angle,
                                          input logic [7:0] count);
    bin_result_t res;
    logic [31:0] factor;
    logic [31:0] ring;
    logic [31:0] sector;
    logic [15:0] first_bin;
    int          usable;
    int          width;
    // The ring is round(r * (n - 0.5) / 50), done exactly in integers.
    factor = (count == 8'd0) ? 32'd0 : 2 * 32'(count) - 32'd1;
    ring   = (32'(radius) * factor + 32'd12800) / 32'd25600;
    usable = (int'(count) > MAX_RINGS) ? MAX_RINGS : int'(count);
    res = '0;
    res.ring_index = (ring > 32'd127) ? 7'd127 : ring[6:0];
    if (ring >= 32'(usable)) begin
      res.out_of_range = 1'b1;
    end else begin
      width  = sector_count(int'(ring));
      sector = (32'(angle) * 32'(width)) >> 16;
      if (sector > 32'(width - 1)) begin
        sector = 32'(width - 1);
      end
      first_bin = '0;
      for (int l = 0; l < int'(ring); l++) begin
        first_bin = first_bin + 16'(sector_count(l));
      end
      res.sector_index = sector[9:0];
      res.bin_index    = first_bin + sector[15:0];
    end
    return res;
  endfunction

  // Hold the hit beat until accepted, possibly after some idle cycles, then
  // queue what it should produce.
  task automatic send_hit(input logic [13:0] radius, input logic [15:0] angle,
                          input bin_result_t expected);
    while (!steady_stream && $urandom_range(99) < IDLE_PERCENT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, angle, radius};
    do @(posedge clk); while (!s_axis_tready);
    pending_bins.push_back(expected);
  endtask

  // Stop sending and wait for every outstanding result beat.
  task automatic drain_hits();
    s_axis_tvalid <= 1'b0;
    while (pending_bins.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // The register is only written with the pipeline empty. Every hit yields a
  // result, so an empty expectation queue means nothing is in flight.
  task automatic write_ring_count(input logic [7:0] count);
    drain_hits();
    cfg_valid <= 1'b1;
    cfg_data  <= count;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ring_count_now = count;
  endtask

  task automatic check_field(input string name, input int expected, input int actual);
    if (expected != actual) begin
      $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
      mismatch_count++;
    end
  endtask

  // Result side: check each accepted beat against the oldest expectation,
  // then choose whether to stall the next cycle.
  always @(posedge clk) begin
    bin_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_bins.size() == 0) begin
        $error("result beat with no hit outstanding: tdata %h tuser %b",
               m_axis_tdata, m_axis_tuser);
        mismatch_count++;
      end else begin
        want = pending_bins.pop_front();
        check_field("bin_index", want.bin_index, m_axis_tdata[15:0]);
        check_field("ring_index", want.ring_index, m_axis_tdata[22:16]);
        check_field("sector_index", want.sector_index, m_axis_tdata[32:23]);
        check_field("out_of_range", want.out_of_range, m_axis_tuser[0]);
      end
    end
    m_axis_tready <= steady_stream || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("polar_ring_sector_binner test failed");
      $finish;
    end
  end

  initial begin
    logic [13:0] radius;
    logic [15:0] angle;
    logic [7:0]  count;
    bin_result_t expected;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table. The first rows run on the reset count of 64 without any
    // register write, which also checks the reset value.
    foreach (directed_hits[i]) begin
      if (8'(directed_hits[i].count) != ring_count_now) begin
        write_ring_count(8'(directed_hits[i].count));
      end
      radius = 14'(directed_hits[i].radius);
      angle  = 16'(directed_hits[i].angle);
      if (directed_hits[i].typed != 0) begin
        expected.bin_index    = 16'(directed_hits[i].bin);
        expected.ring_index   = 7'(directed_hits[i].ring);
        expected.sector_index = 10'(directed_hits[i].sect);
        expected.out_of_range = 1'(directed_hits[i].oor);
      end else begin
        expected = map_hit(radius, angle, ring_count_now);
      end
      send_hit(radius, angle, expected);
    end

    // Random phases, each under its own ring count. Most radii fall on the
    // disc so that the in-range path sees plenty of rings and sectors; the
    // rest cover the full 14-bit field. Phase 1 runs with no idling at all.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: count = 8'd128;
        1: count = 8'd63;
        2: count = 8'd2;
        3: count = 8'd255;
        4: count = 8'($urandom_range(128, 1));
        5: count = 8'd65;
        default: count = 8'($urandom_range(255, 0));
      endcase
      write_ring_count(count);
      steady_stream = (phase == 1);
      for (int n = 0; n < HITS_PER_PHASE; n++) begin
        if ($urandom_range(3) == 0) begin
          radius = 14'($urandom);
        end else begin
          radius = 14'($urandom_range(DISC_EDGE, 0));
        end
        if ($urandom_range(9) == 0) begin
          angle = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        end else begin
          angle = 16'($urandom);
        end
        send_hit(radius, angle, map_hit(radius, angle, ring_count_now));
      end
      steady_stream = 1'b0;
    end

    drain_hits();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_bins.size() == 0) begin
      $display("polar_ring_sector_binner test passed");
    end else begin
      $display("polar_ring_sector_binner test failed");
    end
    $finish;
  end

endmodule

[polar_ring_sector_binner.f]
rtl/core/prsb_pkg.sv
rtl/core/prsb_ring.sv
rtl/core/prsb_sector.sv
rtl/core/polar_ring_sector_binner.sv
rtl/core/prsb_checker.sv
sim/polar_ring_sector_binner_test.sv
